FILE: hw/rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package r2fft_pkg;

  localparam int unsigned MAX_FRAME_DEF   = 1024;
  localparam int unsigned MAX_PAIRS_DEF   = 512;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic signed [15:0] TW_ONE   = 16'sd16384;
  localparam int unsigned        TW_SHIFT = 14;

  typedef enum logic [2:0] {
    MODE_LD_SAMPLE  = 3'd0,
    MODE_LD_TWIDDLE = 3'd1,
    MODE_LD_PAIR    = 3'd2,
    MODE_RUN        = 3'd3,
    MODE_READ       = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2   = 3'd0,
    CFG_INV    = 3'd1,
    CFG_NORM   = 3'd2,
    CFG_PAIRS  = 3'd3,
    CFG_TWIDS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SWP = 2'd1,
    ST_NO_TWID = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [9:0]         entry_index;
    logic signed [31:0] sample_real;
    logic signed [31:0] sample_imag;
    logic signed [15:0] twiddle_real;
    logic signed [15:0] twiddle_imag;
    logic [9:0]         pair_first;
    logic [9:0]         pair_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic t_en;
  } bfly_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/r2fft_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface r2fft_in_if;
  logic                valid;
  logic                ready;
  r2fft_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/r2fft_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface r2fft_out_if;
  logic                 valid;
  logic                 ready;
  r2fft_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/r2fft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module r2fft_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/r2fft_bfly.sv
`timescale 1ns / 1ps
`default_nettype none
module r2fft_bfly #(
  parameter int unsigned SAMPLE_BITS = r2fft_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire r2fft_pkg::bfly_ctl_t          ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] xr_i,
  input  wire logic signed [SAMPLE_BITS-1:0] xi_i,
  input  wire logic signed [15:0]            wr_i,
  input  wire logic signed [15:0]            wi_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ar_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ai_i,
  output logic signed [SAMPLE_BITS-1:0]      sr_o,
  output logic signed [SAMPLE_BITS-1:0]      si_o,
  output logic signed [SAMPLE_BITS-1:0]      dr_o,
  output logic signed [SAMPLE_BITS-1:0]      di_o
);

  localparam int unsigned PW = SAMPLE_BITS + 16;
  localparam int unsigned TW = SAMPLE_BITS + 3;
  localparam int unsigned SW = SAMPLE_BITS + 4;
  localparam logic signed [PW:0] RND =
    (PW+1)'(65'sd1 <<< (r2fft_pkg::TW_SHIFT - 1));
  localparam logic signed [SW-1:0] HI = SW'((65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [TW-1:0] tr_q, ti_q;
  logic signed [PW:0]   tr_full, ti_full;
  logic signed [PW:0]   tr_sh, ti_sh;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
    if (v > HI) begin
      return HI[SAMPLE_BITS-1:0];
    end else if (v < LO) begin
      return LO[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      p_rr_q <= PW'(xr_i) * PW'(wr_i);
      p_ii_q <= PW'(xi_i) * PW'(wi_i);
      p_ri_q <= PW'(xr_i) * PW'(wi_i);
      p_ir_q <= PW'(xi_i) * PW'(wr_i);
    end
    if (ctl_i.t_en) begin
      tr_q <= TW'(tr_sh);
      ti_q <= TW'(ti_sh);
    end
  end

  always_comb begin
    tr_full = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q) + RND;
    ti_full = (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q) + RND;
    tr_sh   = tr_full >>> r2fft_pkg::TW_SHIFT;
    ti_sh   = ti_full >>> r2fft_pkg::TW_SHIFT;
    sr_o    = sat(SW'(ar_i) + SW'(tr_q));
    si_o    = sat(SW'(ai_i) + SW'(ti_q));
    dr_o    = sat(SW'(ar_i) - SW'(tr_q));
    di_o    = sat(SW'(ai_i) - SW'(ti_q));
  end

endmodule
`default_nettype wire

FILE: hw/rtl/radix2_fft_in_place_top.sv
`timescale 1ns / 1ps
`default_nettype none
// In-place radix-2 FFT engine. Samples, twiddles and swap pairs are loaded one per
// transfer; a read returns its sample through the frame memory's registered read port
// and the output register. A run item holds the input until its status transfer is
// issued: it applies the swap pairs, loads each twiddle, runs (N/2)*log2N butterflies
// and rescales every sample if the inverse is normalised. One read and one write port
// of the frame memory serialise this. Only runs and reads need a free result slot.
module radix2_fft_in_place_top #(
  parameter int unsigned MAX_FRAME   = r2fft_pkg::MAX_FRAME_DEF,
  parameter int unsigned MAX_PAIRS   = r2fft_pkg::MAX_PAIRS_DEF,
  parameter int unsigned SAMPLE_BITS = r2fft_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [r2fft_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [r2fft_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  r2fft_in_if.sink                                 in_s,
  r2fft_out_if.source                              out_m
);

  localparam int unsigned LOG_MAX = $clog2(MAX_FRAME + 1) - 1;
  localparam int unsigned AW      = $clog2(MAX_FRAME);
  localparam int unsigned CW      = LOG_MAX + 1;
  localparam int unsigned LW      = $clog2(LOG_MAX + 2);
  localparam int unsigned PAW     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned PCW     = $clog2(MAX_PAIRS + 1);
  localparam int unsigned TCW     = $clog2(MAX_FRAME + 1);
  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned WS      = (SB > 32) ? SB : 32;
  localparam int unsigned WN      = SB + 18;
  localparam logic signed [WS-1:0] SB_HI = WS'((65'sd1 <<< (SB - 1)) - 65'sd1);
  localparam logic signed [WS-1:0] SB_LO = -SB_HI - WS'(1);
  localparam logic signed [WS-1:0] O_HI  = WS'(33'sh0_7fff_ffff);
  localparam logic signed [WS-1:0] O_LO  = -O_HI - WS'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_SW_ADDR, S_SW_CHK, S_SW_RB, S_SW_WA, S_SW_WB,
    S_TW_ADDR, S_TW_DATA, S_BF_RJ, S_BF_RI, S_BF_MUL, S_BF_T, S_BF_WJ, S_BF_WI,
    S_NM_RD, S_NM_WR, S_FIN
  } state_e;

  state_e state_q;

  logic [3:0]  log2_q;
  logic        inv_q, norm_q;
  logic [9:0]  pairs_q;
  logic [10:0] twids_q;

  logic [PCW-1:0] p_q;
  logic [TCW-1:0] tw_q;
  logic [CW-1:0]  half_q, m_q, i_q;
  logic [9:0]     a_q, b_q;
  logic [1:0]     st_q;
  logic           rd_pend_q, rd_oob_q;
  logic           out_valid_q;
  r2fft_pkg::out_item_t out_q;

  logic [2*SB-1:0] tmp_q;
  logic signed [SB-1:0] xjr_q, xji_q, xir_q, xii_q;
  logic signed [15:0]   wr_q, wi_q;

  logic [4:0]      lg5;
  logic [LW-1:0]   l_c;
  logic [CW-1:0]   n_c, step_c, j_c;
  logic [CW:0]     nxt_i, nxt_chk;
  logic [PCW-1:0]  pairs_c;
  logic [TCW-1:0]  tcnt_c;
  logic [16:0]     idx_x, sa_x, sb_x;
  logic [9:0]      sa_c, sb_c;

  logic in_acc, is_res, idx_fr_ok, idx_pr_ok;

  logic            fr_we;
  logic [AW-1:0]   fr_waddr, fr_raddr;
  logic [2*SB-1:0] fr_wdata, fr_rdata;
  logic            tw_we;
  logic [31:0]     tw_wdata, tw_rdata;
  logic            sw_we;
  logic [19:0]     sw_rdata;

  r2fft_pkg::bfly_ctl_t bf_ctl;
  logic signed [SB-1:0] sr, si, dr, di;
  logic signed [15:0]   twr_c, twi_c;
  logic signed [SB-1:0] nm_r, nm_i;

  function automatic logic signed [SB-1:0] sat_sb(input logic signed [WS-1:0] v);
    if (v > SB_HI) begin
      return SB_HI[SB-1:0];
    end else if (v < SB_LO) begin
      return SB_LO[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [SB-1:0] x);
    logic signed [WS-1:0] v;
    v = WS'(x);
    if (v > O_HI) begin
      return 32'sh7fff_ffff;
    end else if (v < O_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat_tw(input logic signed [15:0] v);
    if (v > r2fft_pkg::TW_ONE) begin
      return r2fft_pkg::TW_ONE;
    end else if (v < -r2fft_pkg::TW_ONE) begin
      return -r2fft_pkg::TW_ONE;
    end
    return v;
  endfunction

  function automatic logic signed [SB-1:0] norm(input logic signed [SB-1:0] x,
                                               input logic [LW-1:0] sh);
    logic signed [WN-1:0] bias, v;
    bias = WN'(1) << (sh - LW'(1));
    v    = WN'(x) + bias;
    v    = v >>> sh;
    return v[SB-1:0];
  endfunction

  // frame size, counts and loop arithmetic
  always_comb begin
    lg5 = 5'(log2_q);
    if (lg5 == 5'd0) begin
      lg5 = 5'd1;
    end
    if (32'(lg5) > LOG_MAX) begin
      l_c = LW'(LOG_MAX);
    end else begin
      l_c = LW'(lg5);
    end
    n_c    = CW'(1) << l_c;
    step_c = half_q << 1;
    j_c    = i_q + half_q;
    nxt_i  = {1'b0, i_q} + {1'b0, step_c};
    nxt_chk = nxt_i + {1'b0, half_q};
    if (32'(pairs_q) > MAX_PAIRS) begin
      pairs_c = PCW'(MAX_PAIRS);
    end else begin
      pairs_c = PCW'(pairs_q);
    end
    if (32'(twids_q) > MAX_FRAME) begin
      tcnt_c = TCW'(MAX_FRAME);
    end else begin
      tcnt_c = TCW'(twids_q);
    end
    sa_c  = sw_rdata[19:10];
    sb_c  = sw_rdata[9:0];
    sa_x  = 17'(a_q);
    sb_x  = 17'(b_q);
    idx_x = 17'(in_s.data.entry_index);
    idx_fr_ok = 32'(idx_x) < MAX_FRAME;
    idx_pr_ok = 32'(idx_x) < MAX_PAIRS;
    twr_c = tw_rdata[31:16];
    twi_c = inv_q ? -$signed(tw_rdata[15:0]) : $signed(tw_rdata[15:0]);
    nm_r  = norm(fr_rdata[2*SB-1:SB], l_c + LW'(1));
    nm_i  = norm(fr_rdata[SB-1:0], l_c + LW'(1));
  end

  assign is_res = (in_s.data.mode == r2fft_pkg::MODE_RUN) ||
                  (in_s.data.mode == r2fft_pkg::MODE_READ);
  assign in_s.ready = (state_q == S_IDLE) && !rd_pend_q && (!is_res || !out_valid_q);
  assign in_acc = in_s.valid && in_s.ready;

  assign out_m.valid = out_valid_q;
  assign out_m.data  = out_q;

  // memory port control
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = idx_x[AW-1:0];
    fr_wdata = {sat_sb(WS'(in_s.data.sample_real)), sat_sb(WS'(in_s.data.sample_imag))};
    fr_raddr = idx_x[AW-1:0];
    bf_ctl   = '0;
    tw_we    = in_acc && (in_s.data.mode == r2fft_pkg::MODE_LD_TWIDDLE) && idx_fr_ok;
    tw_wdata = {sat_tw(in_s.data.twiddle_real), sat_tw(in_s.data.twiddle_imag)};
    sw_we    = in_acc && (in_s.data.mode == r2fft_pkg::MODE_LD_PAIR) && idx_pr_ok;
    unique case (state_q)
      S_IDLE: begin
        fr_we = in_acc && (in_s.data.mode == r2fft_pkg::MODE_LD_SAMPLE) && idx_fr_ok;
      end
      S_SW_CHK: fr_raddr = 17'(sa_c) >= 17'(MAX_FRAME) ? '0 : AW'(17'(sa_c));
      S_SW_RB:  fr_raddr = sb_x[AW-1:0];
      S_SW_WA: begin
        fr_we    = 1'b1;
        fr_waddr = sa_x[AW-1:0];
        fr_wdata = fr_rdata;
      end
      S_SW_WB: begin
        fr_we    = 1'b1;
        fr_waddr = sb_x[AW-1:0];
        fr_wdata = tmp_q;
      end
      S_BF_RJ:  fr_raddr = j_c[AW-1:0];
      S_BF_RI:  fr_raddr = i_q[AW-1:0];
      S_BF_MUL: bf_ctl.mul_en = 1'b1;
      S_BF_T:   bf_ctl.t_en = 1'b1;
      S_BF_WJ: begin
        fr_we    = 1'b1;
        fr_waddr = j_c[AW-1:0];
        fr_wdata = {dr, di};
      end
      S_BF_WI: begin
        fr_we    = 1'b1;
        fr_waddr = i_q[AW-1:0];
        fr_wdata = {sr, si};
      end
      S_NM_RD:  fr_raddr = i_q[AW-1:0];
      S_NM_WR: begin
        fr_we    = 1'b1;
        fr_waddr = i_q[AW-1:0];
        fr_wdata = {nm_r, nm_i};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      log2_q      <= 4'd10;
      inv_q       <= 1'b0;
      norm_q      <= 1'b0;
      pairs_q     <= '0;
      twids_q     <= '0;
      p_q         <= '0;
      tw_q        <= '0;
      half_q      <= '0;
      m_q         <= '0;
      i_q         <= '0;
      st_q        <= r2fft_pkg::ST_OK;
      rd_pend_q   <= 1'b0;
      rd_oob_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          r2fft_pkg::CFG_LOG2:  log2_q  <= cfg_wdata_i[3:0];
          r2fft_pkg::CFG_INV:   inv_q   <= cfg_wdata_i[0];
          r2fft_pkg::CFG_NORM:  norm_q  <= cfg_wdata_i[0];
          r2fft_pkg::CFG_PAIRS: pairs_q <= cfg_wdata_i[9:0];
          r2fft_pkg::CFG_TWIDS: twids_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_m.ready) begin
        out_valid_q <= 1'b0;
      end

      rd_pend_q <= 1'b0;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        out_q.status <= r2fft_pkg::ST_OK;
        out_q.result_real <= rd_oob_q ? '0 : sat_32(fr_rdata[2*SB-1:SB]);
        out_q.result_imag <= rd_oob_q ? '0 : sat_32(fr_rdata[SB-1:0]);
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_s.data.mode == r2fft_pkg::MODE_READ)) begin
            rd_pend_q <= 1'b1;
            rd_oob_q  <= !idx_fr_ok;
          end
          if (in_acc && (in_s.data.mode == r2fft_pkg::MODE_RUN)) begin
            p_q    <= '0;
            tw_q   <= '0;
            half_q <= CW'(1);
            m_q    <= '0;
            if (tcnt_c == '0) begin
              st_q    <= r2fft_pkg::ST_NO_TWID;
              state_q <= S_FIN;
            end else begin
              state_q <= S_SW_ADDR;
            end
          end
        end
        S_SW_ADDR: begin
          if (p_q == pairs_c) begin
            state_q <= S_TW_ADDR;
          end else begin
            state_q <= S_SW_CHK;
          end
        end
        S_SW_CHK: begin
          a_q <= sa_c;
          b_q <= sb_c;
          if ((32'(sa_c) >= 32'(n_c)) || (32'(sb_c) >= 32'(n_c))) begin
            st_q    <= r2fft_pkg::ST_BAD_SWP;
            state_q <= S_FIN;
          end else begin
            state_q <= S_SW_RB;
          end
        end
        S_SW_RB: begin
          tmp_q   <= fr_rdata;
          state_q <= S_SW_WA;
        end
        S_SW_WA: state_q <= S_SW_WB;
        S_SW_WB: begin
          p_q     <= p_q + PCW'(1);
          state_q <= S_SW_ADDR;
        end
        S_TW_ADDR: begin
          i_q <= m_q;
          if (half_q >= n_c) begin
            if (inv_q && norm_q) begin
              i_q     <= '0;
              state_q <= S_NM_RD;
            end else begin
              st_q    <= r2fft_pkg::ST_OK;
              state_q <= S_FIN;
            end
          end else if (tw_q >= tcnt_c) begin
            st_q    <= r2fft_pkg::ST_NO_TWID;
            state_q <= S_FIN;
          end else begin
            tw_q    <= tw_q + TCW'(1);
            state_q <= S_TW_DATA;
          end
        end
        S_TW_DATA: begin
          wr_q    <= twr_c;
          wi_q    <= twi_c;
          state_q <= S_BF_RJ;
        end
        S_BF_RJ: state_q <= S_BF_RI;
        S_BF_RI: begin
          xjr_q   <= fr_rdata[2*SB-1:SB];
          xji_q   <= fr_rdata[SB-1:0];
          state_q <= S_BF_MUL;
        end
        S_BF_MUL: begin
          xir_q   <= fr_rdata[2*SB-1:SB];
          xii_q   <= fr_rdata[SB-1:0];
          state_q <= S_BF_T;
        end
        S_BF_T:  state_q <= S_BF_WJ;
        S_BF_WJ: state_q <= S_BF_WI;
        S_BF_WI: begin
          if (nxt_chk < {1'b0, n_c}) begin
            i_q     <= nxt_i[CW-1:0];
            state_q <= S_BF_RJ;
          end else begin
            if (m_q + CW'(1) == half_q) begin
              m_q    <= '0;
              half_q <= step_c;
            end else begin
              m_q <= m_q + CW'(1);
            end
            state_q <= S_TW_ADDR;
          end
        end
        S_NM_RD: state_q <= S_NM_WR;
        S_NM_WR: begin
          i_q <= i_q + CW'(1);
          if (i_q + CW'(1) == n_c) begin
            st_q    <= r2fft_pkg::ST_OK;
            state_q <= S_FIN;
          end else begin
            state_q <= S_NM_RD;
          end
        end
        S_FIN: begin
          out_valid_q       <= 1'b1;
          out_q.status      <= st_q;
          out_q.result_real <= '0;
          out_q.result_imag <= '0;
          state_q           <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  r2fft_ram #(.WIDTH(2 * SB), .DEPTH(MAX_FRAME)) u_frame (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  r2fft_ram #(.WIDTH(32), .DEPTH(MAX_FRAME)) u_twid (
    .clk_i   (clk_i),
    .we_i    (tw_we),
    .waddr_i (idx_x[AW-1:0]),
    .wdata_i (tw_wdata),
    .raddr_i (tw_q[AW-1:0]),
    .rdata_o (tw_rdata)
  );

  r2fft_ram #(.WIDTH(20), .DEPTH(MAX_PAIRS)) u_swap (
    .clk_i   (clk_i),
    .we_i    (sw_we),
    .waddr_i (idx_x[PAW-1:0]),
    .wdata_i ({in_s.data.pair_first, in_s.data.pair_second}),
    .raddr_i (p_q[PAW-1:0]),
    .rdata_o (sw_rdata)
  );

  r2fft_bfly #(.SAMPLE_BITS(SB)) u_bfly (
    .clk_i (clk_i),
    .ctl_i (bf_ctl),
    .xr_i  (xjr_q),
    .xi_i  (xji_q),
    .wr_i  (wr_q),
    .wi_i  (wi_q),
    .ar_i  (xir_q),
    .ai_i  (xii_q),
    .sr_o  (sr),
    .si_o  (si),
    .dr_o  (dr),
    .di_o  (di)
  );

endmodule
`default_nettype wire
